FILE: rtl/fmi_pkg.sv
// Shared constants, types and helpers of the fuzzy inference block.
package fmi_pkg;

  localparam int unsigned SAMPLE_POINTS_DEF = 64;

  // Field widths
  localparam int unsigned BP_W   = 16;
  localparam int unsigned MU_W   = 16;
  localparam int unsigned QUOT_W = 17;

  // Configuration port
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_DEPTH = 7;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_ANTE1 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ANTE2 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ANTE3 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CONS1 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CONS2 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CONS3 = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SPAN  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_LAST  = 3'd7;

  localparam logic [CFG_DW-1:0] SPAN_RESET = 64'h0000_0000_1900_0000;
  localparam logic [MU_W-1:0]   MU_ONE     = 16'h8000;

  // Result of one grading lane
  typedef struct packed {
    logic            done;
    logic [MU_W-1:0] mu;
  } lane_res_t;

  // Pick breakpoint k out of a packed register word
  function automatic logic [BP_W-1:0] bp_field(logic [CFG_DW-1:0] w, logic [1:0] k);
    logic [BP_W-1:0] f;
    f = '0;
    case (k)
      2'd0:    f = w[15:0];
      2'd1:    f = w[31:16];
      2'd2:    f = w[47:32];
      2'd3:    f = w[63:48];
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/fmi_cfg_mem.sv
// Register memory of the rule set with per-entry valid bits for reset values.
module fmi_cfg_mem import fmi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CFG_AW-1:0] waddr_i,
  input  logic [CFG_DW-1:0] wdata_i,
  input  logic [CFG_AW-1:0] raddr_i,
  output logic [CFG_DW-1:0] rdata_o
);

  logic [CFG_DW-1:0]    mem_q [CFG_DEPTH];
  logic [CFG_DEPTH-1:0] vld_q;
  logic [CFG_DW-1:0]    rdata_q;
  logic                 rvld_q;
  logic [CFG_AW-1:0]    raddr_q;

  // Write the array, read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i && waddr_i != REG_LAST) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // Track written entries and the address of the pending read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      raddr_q <= '0;
    end else begin
      if (we_i && waddr_i != REG_LAST) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q  <= (raddr_i != REG_LAST) ? vld_q[raddr_i] : 1'b0;
      raddr_q <= raddr_i;
    end
  end

  // Substitute reset contents for entries never written
  always_comb begin
    if (rvld_q) begin
      rdata_o = rdata_q;
    end else if (raddr_q == REG_SPAN) begin
      rdata_o = SPAN_RESET;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

FILE: rtl/fmi_div.sv
// Restoring divider, one quotient bit per cycle.
module fmi_div import fmi_pkg::*; #(
  parameter int unsigned W = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      rem_i,
  input  logic [QUOT_W-1:0] feed_i,
  input  logic [W-1:0]      div_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(QUOT_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [W-1:0]      rem_q, div_q;
  logic [QUOT_W-1:0] feed_q, quot_q;
  logic [W:0]        trial, diff;
  logic              ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, feed_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  // Count iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      feed_q <= feed_i;
      div_q  <= div_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[W-1:0] : trial[W-1:0];
      feed_q <= {feed_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/fmi_lane.sv
// Trapezoid grading lane: picks the segment and divides out the ramp degree.
module fmi_lane import fmi_pkg::*; #(
  parameter int unsigned SW = 23
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] a_i,
  input  logic signed [SW-1:0] b_i,
  input  logic signed [SW-1:0] c_i,
  input  logic signed [SW-1:0] d_i,
  input  logic signed [SW-1:0] x_i,
  output lane_res_t            res_o
);

  typedef enum logic [1:0] {M_ZERO, M_ONE, M_RISE, M_FALL} mode_e;

  mode_e             mode;
  logic [SW-1:0]     delta, run;
  logic              ramp, div_done, wait_q, done_q;
  logic [QUOT_W-1:0] quot;
  logic [MU_W-1:0]   mu_q;

  // Ordered segment tests, later ones win
  always_comb begin
    mode = M_ZERO;
    if (x_i > a_i && x_i < b_i) mode = M_RISE;
    if (x_i >= b_i && x_i <= c_i) mode = M_ONE;
    if (x_i > c_i && x_i < d_i) mode = M_FALL;
    if (x_i > d_i) mode = M_ZERO;
  end

  assign ramp  = (mode == M_RISE) || (mode == M_FALL);
  assign delta = (mode == M_FALL) ? SW'(d_i - x_i) : SW'(x_i - a_i);
  assign run   = (mode == M_FALL) ? SW'(d_i - c_i) : SW'(b_i - a_i);

  fmi_div #(.W(SW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && ramp),
    .rem_i  ({2'b00, delta[SW-1:2]}),
    .feed_i ({delta[1:0], (QUOT_W-2)'(0)}),
    .div_i  (run),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Hold the degree, pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
      done_q <= 1'b0;
      mu_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ramp) begin
          wait_q <= 1'b1;
        end else begin
          done_q <= 1'b1;
          mu_q   <= (mode == M_ONE) ? MU_ONE : '0;
        end
      end else if (wait_q && div_done) begin
        wait_q <= 1'b0;
        done_q <= 1'b1;
        mu_q   <= quot[MU_W-1:0];
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.mu   = mu_q;

endmodule

FILE: rtl/mamdani_fuzzy_inference.sv
// Flow: the rule memory is read into registers, the three antecedents are graded, then each output
// point is graded by the lanes, using the ramp divider where a ramp is hit, and is accumulated;
// then comes the centroid division.
// Throughput: one item at a time; the next is taken once the result sits in the output register.
// Reset clears control state and marks all rule registers as holding their reset values.
module mamdani_fuzzy_inference import fmi_pkg::*; #(
  parameter int unsigned SAMPLE_POINTS = SAMPLE_POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [BP_W-1:0]   crisp_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [BP_W-1:0]   crisp_out_o,
  output logic                     no_rule_fired_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_AW-1:0]        cfg_index_i,
  input  logic [CFG_DW-1:0]        cfg_data_i
);

  localparam int unsigned LOG  = (SAMPLE_POINTS > 1) ? $clog2(SAMPLE_POINTS) : 1;
  localparam int unsigned SW   = 17 + LOG;
  localparam int unsigned NUMW = 32 + 2 * LOG;
  localparam int unsigned DENW = 16 + LOG;
  localparam int unsigned FW   = 16 + 2 * LOG;
  localparam int unsigned ICW  = LOG;
  localparam logic signed [SW-1:0] STEPS_S = SW'(SAMPLE_POINTS - 1);
  localparam logic [FW-1:0]        STEPS_U = FW'(SAMPLE_POINTS - 1);
  localparam logic [ICW-1:0]       LAST_I  = ICW'(SAMPLE_POINTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ANT, S_SAMP, S_MAC, S_FIN, S_FDIV, S_OUT
  } state_e;

  state_e               state_q;
  logic [CFG_AW-1:0]    cnt_q, cidx, raddr;
  logic [CFG_DW-1:0]    rdata;
  logic [BP_W-1:0]      x_q;
  logic [CFG_DW-1:0]    ante_q [3];
  logic signed [SW-1:0] cbp_q [3][4];
  logic signed [SW-1:0] scaled [4];
  logic signed [SW-1:0] span_lo, span_hi;
  logic signed [SW-1:0] y_q, dy_q;
  logic [MU_W-1:0]      w_q [3];
  logic [MU_W-1:0]      clip [3];
  logic [MU_W-1:0]      agg, agg_q;
  logic [ICW-1:0]       i_q;
  logic signed [NUMW-1:0] num_q, nabs_q;
  logic signed [SW+MU_W:0] prod;
  logic [DENW-1:0]      den_q;
  logic [FW-1:0]        dd_q;
  logic                 neg_q, go_q, fgo_q, fdone, all_done;
  logic [2:0]           dn_q, lane_done;
  logic [QUOT_W-1:0]    fquot;
  logic [BP_W-1:0]      res_q, out_q;
  logic                 res_flag_q, flag_q, out_valid_q;
  logic signed [SW-1:0] la [3], lb [3], lc [3], ld [3], lx;
  lane_res_t            lres [3];

  // Rule register memory
  assign cfg_ready_o = 1'b1;
  assign raddr       = cnt_q;
  assign cidx        = cnt_q - CFG_AW'(1);

  fmi_cfg_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .waddr_i(cfg_index_i),
    .wdata_i(cfg_data_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Scale consequent breakpoints by the step count and extract the universe ends
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      scaled[k] = SW'(signed'(bp_field(rdata, 2'(k)))) * STEPS_S;
    end
    span_lo = SW'(signed'(rdata[15:0]));
    span_hi = SW'(signed'(rdata[31:16]));
  end

  // Feed lanes with the antecedent or the current sample point
  assign lx = (state_q == S_ANT) ? SW'(signed'(x_q)) : y_q;

  for (genvar r = 0; r < 3; r++) begin : g_lane
    assign la[r] = (state_q == S_ANT) ? SW'(signed'(bp_field(ante_q[r], 2'd0))) : cbp_q[r][0];
    assign lb[r] = (state_q == S_ANT) ? SW'(signed'(bp_field(ante_q[r], 2'd1))) : cbp_q[r][1];
    assign lc[r] = (state_q == S_ANT) ? SW'(signed'(bp_field(ante_q[r], 2'd2))) : cbp_q[r][2];
    assign ld[r] = (state_q == S_ANT) ? SW'(signed'(bp_field(ante_q[r], 2'd3))) : cbp_q[r][3];

    fmi_lane #(.SW(SW)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(go_q),
      .a_i    (la[r]),
      .b_i    (lb[r]),
      .c_i    (lc[r]),
      .d_i    (ld[r]),
      .x_i    (lx),
      .res_o  (lres[r])
    );

    assign lane_done[r] = lres[r].done;
    assign clip[r] = (lres[r].mu > w_q[r]) ? w_q[r] : lres[r].mu;
  end

  assign all_done = &(dn_q | lane_done);

  // Clip and combine by maximum
  always_comb begin
    agg = clip[0];
    if (clip[1] > agg) agg = clip[1];
    if (clip[2] > agg) agg = clip[2];
  end

  assign prod = y_q * $signed({1'b0, agg_q});

  // Centroid divider
  fmi_div #(.W(FW)) u_fdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(fgo_q),
    .rem_i  (FW'(nabs_q >>> QUOT_W)),
    .feed_i (nabs_q[QUOT_W-1:0]),
    .div_i  (dd_q),
    .done_o (fdone),
    .quot_o (fquot)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      go_q        <= 1'b0;
      fgo_q       <= 1'b0;
      dn_q        <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      go_q  <= 1'b0;
      fgo_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q <= cnt_q + CFG_AW'(1);
          if (cnt_q == REG_LAST) begin
            state_q <= S_ANT;
            go_q    <= 1'b1;
            dn_q    <= '0;
            i_q     <= '0;
          end
        end
        S_ANT: begin
          if (all_done) begin
            state_q <= S_SAMP;
            go_q    <= 1'b1;
            dn_q    <= '0;
          end else begin
            dn_q <= dn_q | lane_done;
          end
        end
        S_SAMP: begin
          if (all_done) begin
            state_q <= S_MAC;
            dn_q    <= '0;
          end else begin
            dn_q <= dn_q | lane_done;
          end
        end
        S_MAC: begin
          i_q <= i_q + ICW'(1);
          if (i_q == LAST_I) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_SAMP;
            go_q    <= 1'b1;
          end
        end
        S_FIN: begin
          if (den_q == '0) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_FDIV;
            fgo_q   <= 1'b1;
          end
        end
        S_FDIV: begin
          if (fdone) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q <= crisp_in_i;
      end
      S_LOAD: begin
        if (cnt_q != '0) begin
          case (cidx)
            REG_ANTE1: ante_q[0] <= rdata;
            REG_ANTE2: ante_q[1] <= rdata;
            REG_ANTE3: ante_q[2] <= rdata;
            REG_CONS1: cbp_q[0]  <= scaled;
            REG_CONS2: cbp_q[1]  <= scaled;
            REG_CONS3: cbp_q[2]  <= scaled;
            REG_SPAN: begin
              y_q  <= span_lo * STEPS_S;
              dy_q <= span_hi - span_lo;
            end
            default: begin
            end
          endcase
        end
        num_q <= '0;
        den_q <= '0;
      end
      S_ANT: begin
        if (all_done) begin
          for (int r = 0; r < 3; r++) w_q[r] <= lres[r].mu;
        end
      end
      S_SAMP: begin
        if (all_done) agg_q <= agg;
      end
      S_MAC: begin
        num_q <= num_q + NUMW'(prod);
        den_q <= den_q + DENW'(agg_q);
        y_q   <= y_q + dy_q;
      end
      S_FIN: begin
        dd_q       <= FW'(den_q) * STEPS_U;
        nabs_q     <= (num_q < 0) ? -num_q : num_q;
        neg_q      <= num_q < 0;
        res_q      <= '0;
        res_flag_q <= (den_q == '0);
      end
      S_FDIV: begin
        if (fdone) begin
          res_q <= neg_q ? BP_W'(-fquot) : fquot[BP_W-1:0];
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q  <= res_q;
          flag_q <= res_flag_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign crisp_out_o     = out_q;
  assign no_rule_fired_o = flag_q;

endmodule

FILE: rtl/fmi_chk.sv
// Port-level checks of the fuzzy inference block and their binding.
module fmi_chk import fmi_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [BP_W-1:0] crisp_out_o,
  input logic                   no_rule_fired_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(crisp_out_o) && $stable(no_rule_fired_o))
    else $error("stalled result changed");

  // An empty aggregate reports zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_rule_fired_o |-> crisp_out_o == '0)
    else $error("empty aggregate with nonzero output");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while busy");

endmodule

bind mamdani_fuzzy_inference fmi_chk u_fmi_chk (.*);

FILE: tb/sv/tb_mamdani_fuzzy_inference.sv
// Self-checking testbench for the three-rule Mamdani fuzzy inference block.
module tb_mamdani_fuzzy_inference;
  import fmi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS       = SAMPLE_POINTS_DEF;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          DRAIN_WAIT = 60;
  localparam int          HOLD_LEN   = 4000;

  typedef struct {
    logic [BP_W-1:0] value;
    logic            flag;
  } centroid_t;

  typedef struct {
    logic [BP_W-1:0] x;
    bit              typed;
    logic [BP_W-1:0] out;
    logic            flag;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [BP_W-1:0] crisp_in_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [BP_W-1:0] crisp_out_o;
  logic                   no_rule_fired_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_AW-1:0]      cfg_index_i = '0;
  logic [CFG_DW-1:0]      cfg_data_i = '0;

  // Shadow copy of the rule registers
  logic [63:0] ante_q [3];
  logic [63:0] cons_q [3];
  logic [31:0] span_q;

  centroid_t pending_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        out_stall = 0;
  int        hold_cnt = 0;
  bit        idle_en = 1'b0;

  mamdani_fuzzy_inference dut (.*);

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pack four Q9.6 breakpoints, a in the low bits
  function automatic logic [63:0] trap(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  // Membership degree of x in a trapezoid whose breakpoints are scaled by s
  function automatic longint degree(logic [63:0] w, longint x, longint s);
    longint a, b, c, d, mu;
    a = longint'($signed(w[15:0])) * s;
    b = longint'($signed(w[31:16])) * s;
    c = longint'($signed(w[47:32])) * s;
    d = longint'($signed(w[63:48])) * s;
    mu = 0;
    if (x > a && x < b) mu = ((x - a) * 32768) / (b - a);
    if (x >= b && x <= c) mu = 32768;
    if (x > c && x < d) mu = ((d - x) * 32768) / (d - c);
    if (x > d) mu = 0;
    return mu;
  endfunction

  // Clip, aggregate by maximum and take the centroid
  function automatic centroid_t centroid(logic [BP_W-1:0] xin);
    longint x, lo, hi, steps, y, agg, mu, num, den;
    longint w [3];
    centroid_t res;
    x = longint'($signed(xin));
    lo = longint'($signed(span_q[15:0]));
    hi = longint'($signed(span_q[31:16]));
    steps = NPTS - 1;
    num = 0;
    den = 0;
    for (int r = 0; r < 3; r++) w[r] = degree(ante_q[r], x, 1);
    for (longint i = 0; i <= steps; i++) begin
      y = i * hi + (steps - i) * lo;
      agg = 0;
      for (int r = 0; r < 3; r++) begin
        mu = degree(cons_q[r], y, steps);
        if (mu > w[r]) mu = w[r];
        if (mu > agg) agg = mu;
      end
      num += y * agg;
      den += agg;
    end
    if (den == 0) begin
      res.value = '0;
      res.flag = 1'b1;
    end else begin
      res.value = 16'(num / (den * steps));
      res.flag = 1'b0;
    end
    return res;
  endfunction

  // Check results against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    centroid_t e;
    if (in_valid_i && in_ready_o || out_valid_o && out_ready_i || cfg_valid_i && cfg_ready_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      out_stall = idle_en ? $urandom_range(0, 4) : 0;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", crisp_out_o, no_rule_fired_o);
      end else begin
        e = pending_q.pop_front();
        if (e.value !== crisp_out_o || e.flag !== no_rule_fired_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: crisp_out exp %h got %h, no_rule_fired exp %b got %b",
                     e.value, crisp_out_o, e.flag, no_rule_fired_o);
        end
      end
    end
  end

  // Drive the result side, with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Write one register; the caller drops valid after the batch
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ANTE1, REG_ANTE2, REG_ANTE3: ante_q[idx - REG_ANTE1] = data;
      REG_CONS1, REG_CONS2, REG_CONS3: cons_q[idx - REG_CONS1] = data;
      REG_SPAN:                        span_q = data[31:0];
      default:                         ;
    endcase
    @(negedge clk_i);
  endtask

  // Load a full rule set, plus an ignored write to the unused index
  task automatic load_rules(logic [63:0] a1, a2, a3, c1, c2, c3, logic [63:0] span);
    write_reg(REG_ANTE1, a1);
    write_reg(REG_ANTE2, a2);
    write_reg(REG_ANTE3, a3);
    write_reg(REG_CONS1, c1);
    write_reg(REG_CONS2, c2);
    write_reg(REG_CONS3, c3);
    write_reg(REG_SPAN, span);
    write_reg(REG_LAST, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one input; a typed row carries its own expected result
  task automatic send_item(logic [BP_W-1:0] x, bit typed = 0, logic [BP_W-1:0] eo = '0,
                           logic ef = 1'b0);
    int gap;
    centroid_t e;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    crisp_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      e.value = eo;
      e.flag = ef;
    end else begin
      e = centroid(x);
    end
    pending_q.push_back(e);
    @(negedge clk_i);
  endtask

  // Drop valid and let every result come back before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Random trapezoid: mostly ordered, sometimes arbitrary bits
  function automatic logic [63:0] rand_trap();
    int p, q, r, s;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    p = $urandom_range(0, 12000) - 6000;
    q = p + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000));
    r = q + $urandom_range(0, 2000);
    s = r + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000));
    return trap(p, q, r, s);
  endfunction

  function automatic logic [63:0] rand_span();
    int lo, hi;
    case ($urandom_range(0, 5))
      0:       return {32'h0, $urandom};
      1: begin
        lo = $urandom_range(0, 12000) - 6000;
        return {32'h0, lo[15:0], lo[15:0]};
      end
      default: begin
        lo = $urandom_range(0, 6000) - 7000;
        hi = lo + $urandom_range(1, 14000);
        return $urandom_range(0, 3) == 0 ? {32'h0, lo[15:0], hi[15:0]}
                                         : {32'h0, hi[15:0], lo[15:0]};
      end
    endcase
  endfunction

  // Inputs near the antecedent breakpoints, plus full-range noise
  task automatic send_random(int n);
    logic [BP_W-1:0] x;
    logic [63:0]     w;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        x = 16'($urandom);
      end else begin
        w = ante_q[$urandom_range(0, 2)];
        x = w[16*$urandom_range(0, 3) +: 16] + 16'($urandom_range(0, 1600)) - 16'd800;
      end
      send_item(x);
    end
  endtask

  stim_row_t rows [] = '{
    // after reset only x = 0 fires, at the single sample point y = 0
    '{16'h0000, 1, 16'h0000, 1'b0},
    '{16'h0001, 1, 16'h0000, 1'b1},
    '{16'h8000, 1, 16'h0000, 1'b1},
    '{16'h7fff, 1, 16'h0000, 1'b1},
    // the rest run against the set of triangles and trapezoids
    '{16'h8000, 0, '0, 1'b0}, '{16'h7fff, 0, '0, 1'b0},
    '{-16'sd1281, 0, '0, 1'b0}, '{-16'sd1280, 0, '0, 1'b0},
    '{-16'sd960, 0, '0, 1'b0}, '{-16'sd640, 0, '0, 1'b0},
    '{-16'sd320, 0, '0, 1'b0}, '{16'sd0, 0, '0, 1'b0},
    '{16'sd320, 0, '0, 1'b0}, '{16'sd640, 0, '0, 1'b0},
    '{16'sd1000, 0, '0, 1'b0}, '{16'sd1280, 0, '0, 1'b0},
    '{16'sd1281, 0, '0, 1'b0}
  };

  initial begin
    for (int r = 0; r < 3; r++) begin
      ante_q[r] = '0;
      cons_q[r] = '0;
    end
    span_q = SPAN_RESET[31:0];
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: reset values first, then a rule set of triangles and trapezoids
    for (int k = 0; k < rows.size(); k++) begin
      if (k == 4) begin
        drain();
        load_rules(trap(-1280, -640, -640, 0), trap(-640, 0, 0, 640),
                   trap(0, 640, 1280, 1280), trap(0, 0, 1600, 3200),
                   trap(1600, 3200, 3200, 4800), trap(3200, 4800, 6400, 6400),
                   SPAN_RESET);
      end
      send_item(rows[k].x, rows[k].typed, rows[k].out, rows[k].flag);
    end

    // Long hold-off on the result side while inputs are still offered
    idle_en = 1'b1;
    hold_cnt = HOLD_LEN;
    send_random(20);

    // Identical antecedents (ties) over a reversed universe
    drain();
    load_rules(trap(-900, -300, 300, 900), trap(-900, -300, 300, 900),
               trap(-900, -300, 300, 900), trap(-3000, -1000, -1000, 0),
               trap(-1000, 0, 0, 1000), trap(0, 1000, 1000, 3000),
               {32'h0, 16'(-6400), 16'(6400)});
    send_random(20);

    // Extreme breakpoints and the widest universe
    drain();
    load_rules(trap(-32768, -32768, 32767, 32767), trap(-32768, 0, 0, 32767),
               trap(32767, 32767, 32767, 32767), trap(-32768, 0, 0, 32767),
               trap(-32768, -32768, -32768, -32768), trap(0, 32767, 32767, 32767),
               {32'h0, 16'h7fff, 16'h8000});
    send_random(20);

    // Empty universe, vertical edges and unordered breakpoints
    idle_en = 1'b0;
    drain();
    load_rules(trap(500, -500, 300, -300), trap(-200, -200, 200, 200),
               trap(100, 100, 100, 100), trap(100, 100, 100, 100),
               trap(300, -300, 200, -200), trap(0, 200, 100, 50),
               {32'h0, 16'sd100, 16'sd100});
    send_random(20);

    // Random rule sets
    for (int p = 0; p < 8; p++) begin
      drain();
      idle_en = (p % 3) != 2;
      load_rules(rand_trap(), rand_trap(), rand_trap(), rand_trap(), rand_trap(),
                 rand_trap(), rand_span());
      send_random(75);
    end

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
